### design/bmp_pkg.sv
// ----------------------------------------------------------------------------
// BMP decoder package
// Shared constants and the pixel word type passed from the parser to the packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmp_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int DIM_BITS    = 13;
   localparam int ROW_BITS    = 12;
   localparam int ROWB_BITS   = 15;
   localparam int ADDR_BITS   = 24;
   localparam int HDR_BYTES   = 54;
   localparam int OFFSET_POS  = 10;
   localparam int WIDTH_POS   = 18;
   localparam int HEIGHT_POS  = 22;

   // Depth of the queue between parser and packer.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ADDR_BITS-1:0] pixel_address;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
      logic                 last_pixel;
      logic                 header_error;
   } item_type;

endpackage

### design/bmp_front.sv
// ----------------------------------------------------------------------------
// BMP header and pixel parser
// Captures offset and dimensions, skips gap and row padding, and emits one
// pixel word per blue, green, red triple with its flipped frame address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        data_byte,
   input  logic              file_start,
   output logic              item_valid,
   output bmp_pkg::item_type item
);
   import bmp_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   phase_type             phase_ff, phase_in, phase_cur;
   logic [31:0]           pos_ff, pos_in, pos_cur;
   logic [31:0]           offset_ff, offset_in;
   logic [31:0]           raw_w_ff, raw_w_in;
   logic [31:0]           raw_h_ff, raw_h_in;
   logic [DIM_BITS-1:0]   width_ff, width_in;
   logic [ROW_BITS-1:0]   height_m1_ff, height_m1_in;
   logic [ROWB_BITS-1:0]  row_bytes_ff, row_bytes_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [ROWB_BITS-1:0]  k_ff, k_in;
   logic [1:0]            lane_ff, lane_in;
   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [ADDR_BITS-1:0]  base_ff, base_in;
   logic [7:0]            blue_ff, blue_in;
   logic [7:0]            green_ff, green_in;

   logic                  dims_ok;
   logic [ROW_BITS-1:0]   raw_h_m1;
   logic [DIM_BITS+ROW_BITS-1:0] base_product;
   logic                  is_last;

   assign dims_ok = (raw_w_ff != 32'd0) && (raw_w_ff <= 32'(MAX_WIDTH)) &&
                    (raw_h_ff != 32'd0) && (raw_h_ff <= 32'(MAX_HEIGHT));
   assign raw_h_m1     = raw_h_ff[ROW_BITS-1:0] - ROW_BITS'(1);
   assign base_product = {{DIM_BITS{1'b0}}, raw_h_m1} *
                         {{ROW_BITS{1'b0}}, raw_w_ff[DIM_BITS-1:0]};
   assign is_last      = (row_ff == height_m1_ff) && (col_ff == width_ff - DIM_BITS'(1));

   always_comb begin
      phase_cur    = file_start ? PH_HEADER : phase_ff;
      pos_cur      = file_start ? 32'd0 : pos_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      offset_in    = offset_ff;
      raw_w_in     = raw_w_ff;
      raw_h_in     = raw_h_ff;
      width_in     = width_ff;
      height_m1_in = height_m1_ff;
      row_bytes_in = row_bytes_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      lane_in      = lane_ff;
      col_in       = col_ff;
      base_in      = base_ff;
      blue_in      = blue_ff;
      green_in     = green_ff;
      item_valid   = 1'b0;
      item         = '0;
      if (in_valid) begin
         phase_in = phase_cur;
         pos_in   = pos_cur;
         case (phase_cur)
            PH_HEADER: begin
               pos_in = pos_cur + 32'd1;
               if (pos_cur >= 32'(OFFSET_POS) && pos_cur < 32'(OFFSET_POS + 4)) begin
                  offset_in = {data_byte, offset_ff[31:8]};
               end else if (pos_cur >= 32'(WIDTH_POS) && pos_cur < 32'(WIDTH_POS + 4)) begin
                  raw_w_in = {data_byte, raw_w_ff[31:8]};
               end else if (pos_cur >= 32'(HEIGHT_POS) &&
                            pos_cur < 32'(HEIGHT_POS + 4)) begin
                  raw_h_in = {data_byte, raw_h_ff[31:8]};
               end
               if (pos_cur == 32'(HDR_BYTES - 1)) begin
                  if (!dims_ok) begin
                     phase_in          = PH_DONE;
                     item_valid        = 1'b1;
                     item.header_error = 1'b1;
                  end else begin
                     width_in     = raw_w_ff[DIM_BITS-1:0];
                     height_m1_in = raw_h_m1;
                     row_bytes_in = (ROWB_BITS'(raw_w_ff[DIM_BITS-1:0]) +
                                     ROWB_BITS'({raw_w_ff[DIM_BITS-1:0], 1'b0}) +
                                     ROWB_BITS'(3)) & ~ROWB_BITS'(3);
                     base_in      = base_product[ADDR_BITS-1:0];
                     row_in       = '0;
                     k_in         = '0;
                     lane_in      = 2'd0;
                     col_in       = '0;
                     if (offset_ff > 32'(HDR_BYTES) && !offset_ff[31]) begin
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_PIXELS;
                     end
                  end
               end
            end
            PH_SKIP: begin
               pos_in = pos_cur + 32'd1;
               if (pos_cur + 32'd1 >= offset_ff) begin
                  phase_in = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               if (col_ff < width_ff) begin
                  case (lane_ff)
                     2'd0: begin
                        blue_in = data_byte;
                        lane_in = 2'd1;
                     end
                     2'd1: begin
                        green_in = data_byte;
                        lane_in  = 2'd2;
                     end
                     default: begin
                        item_valid         = 1'b1;
                        item.pixel_address = base_ff + ADDR_BITS'(col_ff);
                        item.red           = data_byte;
                        item.green         = green_ff;
                        item.blue          = blue_ff;
                        item.last_pixel    = is_last;
                        lane_in            = 2'd0;
                        col_in             = col_ff + DIM_BITS'(1);
                     end
                  endcase
               end
               if (k_ff + ROWB_BITS'(1) >= row_bytes_ff) begin
                  k_in    = '0;
                  lane_in = 2'd0;
                  col_in  = '0;
                  row_in  = row_ff + ROW_BITS'(1);
                  base_in = base_ff - ADDR_BITS'(width_ff);
               end else begin
                  k_in = k_ff + ROWB_BITS'(1);
               end
               if (item_valid && is_last) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
      offset_ff    <= offset_in;
      raw_w_ff     <= raw_w_in;
      raw_h_ff     <= raw_h_in;
      width_ff     <= width_in;
      height_m1_ff <= height_m1_in;
      row_bytes_ff <= row_bytes_in;
      row_ff       <= row_in;
      k_ff         <= k_in;
      lane_ff      <= lane_in;
      col_ff       <= col_in;
      base_ff      <= base_in;
      blue_ff      <= blue_in;
      green_ff     <= green_in;
   end

   // While in the header phase, the byte position stays inside the header.
   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (pos_ff < 32'(HDR_BYTES)))
      else $error("header byte position ran past the header");

   // An error word ends the file and carries no pixel.
   a_error_done: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.header_error) |=> (phase_ff == PH_DONE))
      else $error("parser did not stop after a header error");

endmodule

### design/bmp_queue.sv
// ----------------------------------------------------------------------------
// BMP pixel queue
// Small first-in first-out buffer that decouples the parser from the packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bmp_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output bmp_pkg::item_type pop_item
);
   import bmp_pkg::*;

   item_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("word pushed into a full queue");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - COUNT_BITS'(1)))
      else $error("queue count did not drop on a pop");

endmodule

### design/bmp_back.sv
// ----------------------------------------------------------------------------
// BMP pixel packer
// Packs blue, green, red bytes into RGB565 and holds the result word in an
// output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  bmp_pkg::item_type             q_item,
   output logic                          q_pop,
   output logic                          out_empty,
   input  logic                          out_pop,
   output logic [bmp_pkg::ADDR_BITS-1:0] pixel_address,
   output logic [15:0]                   pixel_color,
   output logic                          last_pixel,
   output logic                          header_error
);
   import bmp_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [15:0]          color_ff, color_in;
   logic                 last_ff;
   logic                 error_ff;

   assign q_pop    = !q_empty && (!valid_ff || out_pop);
   assign valid_in = q_pop || (valid_ff && !out_pop);
   assign color_in = {q_item.red[7:3], q_item.green[7:2], q_item.blue[7:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (q_pop) begin
         addr_ff  <= q_item.pixel_address;
         color_ff <= color_in;
         last_ff  <= q_item.last_pixel;
         error_ff <= q_item.header_error;
      end
   end

   assign out_empty     = !valid_ff;
   assign pixel_address = addr_ff;
   assign pixel_color   = color_ff;
   assign last_pixel    = last_ff;
   assign header_error  = error_ff;

endmodule

### design/bmp24_to_rgb565_stream_decoder.sv
// ----------------------------------------------------------------------------
// BMP 24-bit to RGB565 stream decoder
// Takes a 24-bit BMP file one byte per clock while req_full is low and gives
// one RGB565 word per pixel, with its top-down frame address. The parser
// accepts a byte every cycle that the queue is not full; its per-byte counter
// update is the only work on the byte path, so the sustained rate is one byte
// per clock whenever the result side keeps popping. A pixel word is written
// into a four-word queue when its red byte is taken, and reaches the result
// ports from the packer's output register.
// A header with a zero, negative or oversized width or height gives a single
// word with header_error set, and no pixels follow until file_start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp24_to_rgb565_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [23:0] rsp_pixel_address,
   output logic [15:0] rsp_pixel_color,
   output logic        rsp_last_pixel,
   output logic        rsp_header_error
);
   import bmp_pkg::*;

   logic     accept;
   logic     front_valid;
   item_type front_item;
   logic     q_empty;
   logic     q_pop;
   item_type q_item;

   assign accept = req_push && !req_full;

   bmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .item_valid (front_valid),
      .item       (front_item)
   );

   bmp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_item)
   );

   bmp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .out_empty     (rsp_empty),
      .out_pop       (rsp_pop),
      .pixel_address (rsp_pixel_address),
      .pixel_color   (rsp_pixel_color),
      .last_pixel    (rsp_last_pixel),
      .header_error  (rsp_header_error)
   );

endmodule

### tb/sv/bmp24_to_rgb565_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// BMP 24-bit to RGB565 stream decoder testbench
// Streams generated BMP files into the decoder, one byte per word, and keeps
// its own model of the header parser and pixel packer.
// Each word popped from the result side is compared field by field with the
// oldest predicted pixel. The stimulus covers several kinds of files:
//   - directed files for offsets, color extremes, header errors and the
//     largest frames;
//   - bursts with no idling;
//   - a long receiver hold-off;
//   - random files, some truncated, broken or malformed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp24_to_rgb565_stream_decoder_tb;

   import bmp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 200;
   localparam int MAX_REPORTS    = 40;
   localparam int RANDOM_BYTES   = 50;
   localparam logic [31:0] NO_TRUNCATION = 32'hffff_ffff;
   localparam int RANDOM_FILL    = -1;

   typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_DONE} parse_phase_type;

   typedef struct {
      logic [23:0] address;
      logic [15:0] color;
      logic        last;
      logic        error;
   } pixel_word_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_push       = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte  = 8'h00;
   logic        req_file_start = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop        = 1'b0;
   logic [23:0] rsp_pixel_address;
   logic [15:0] rsp_pixel_color;
   logic        rsp_last_pixel;
   logic        rsp_header_error;

   pixel_word_type pending_pixels[$];
   int          mismatch_count = 0;
   int          stall_cycles   = 0;
   int          bytes_sent     = 0;
   bit          send_idle_on   = 1'b1;
   bit          pop_idle_on    = 1'b1;
   bit          hold_request   = 1'b0;

   parse_phase_type dec_phase;
   logic [31:0]  dec_pos;
   logic [31:0]  dec_offset;
   logic [31:0]  dec_raw_width;
   logic [31:0]  dec_raw_height;
   logic [12:0]  dec_width;
   logic [12:0]  dec_height;
   logic [11:0]  dec_row;
   logic [14:0]  dec_row_byte;
   logic [23:0]  dec_row_base;
   logic [7:0]   dec_blue;
   logic [7:0]   dec_green;

   bmp24_to_rgb565_stream_decoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_file_start    (req_file_start),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_pixel    (rsp_last_pixel),
      .rsp_header_error  (rsp_header_error)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit dim_valid(input logic [31:0] raw, input int unsigned limit);
      return raw != 0 && !raw[31] && raw <= limit;
   endfunction

   task automatic clear_decoder();
      dec_phase      = PH_HEADER;
      dec_pos        = '0;
      dec_offset     = '0;
      dec_raw_width  = '0;
      dec_raw_height = '0;
      dec_width      = '0;
      dec_height     = '0;
      dec_row        = '0;
      dec_row_byte   = '0;
      dec_row_base   = '0;
      dec_blue       = '0;
      dec_green      = '0;
   endtask

   task automatic decode_bmp_byte(input logic [7:0] b, input logic start);
      logic [31:0] pos;
      int unsigned k;
      int unsigned col;
      int unsigned row_len;
      int unsigned wd;
      int unsigned ht;
      pixel_word_type word;
      if (start) clear_decoder();
      pos = dec_pos;
      case (dec_phase)
         PH_HEADER: begin
            if (pos >= OFFSET_POS && pos < OFFSET_POS + 4)
               dec_offset[8*(pos-OFFSET_POS) +: 8] = b;
            else if (pos >= WIDTH_POS && pos < WIDTH_POS + 4)
               dec_raw_width[8*(pos-WIDTH_POS) +: 8] = b;
            else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + 4)
               dec_raw_height[8*(pos-HEIGHT_POS) +: 8] = b;
            dec_pos = pos + 1;
            if (pos == HDR_BYTES - 1) begin
               if (!dim_valid(dec_raw_width, MAX_WIDTH) ||
                   !dim_valid(dec_raw_height, MAX_HEIGHT)) begin
                  dec_phase     = PH_DONE;
                  word.address  = '0;
                  word.color    = '0;
                  word.last     = 1'b0;
                  word.error    = 1'b1;
                  pending_pixels.push_back(word);
               end else begin
                  dec_width    = dec_raw_width[12:0];
                  dec_height   = dec_raw_height[12:0];
                  dec_row      = '0;
                  dec_row_byte = '0;
                  wd           = 32'(dec_width);
                  ht           = 32'(dec_height);
                  dec_row_base = 24'((ht - 1) * wd);
                  if (dec_offset > HDR_BYTES && !dec_offset[31])
                     dec_phase = PH_SKIP;
                  else
                     dec_phase = PH_PIXELS;
               end
            end
         end
         PH_SKIP: begin
            dec_pos = pos + 1;
            if (pos + 1 >= dec_offset) dec_phase = PH_PIXELS;
         end
         PH_PIXELS: begin
            k       = 32'(dec_row_byte);
            wd      = 32'(dec_width);
            ht      = 32'(dec_height);
            row_len = (wd * 3 + 3) & ~32'd3;
            if (k < wd * 3) begin
               case (k % 3)
                  0: dec_blue = b;
                  1: dec_green = b;
                  default: begin
                     col          = k / 3;
                     word.address = dec_row_base + col[23:0];
                     word.color   = {b[7:3], dec_green[7:2], dec_blue[7:3]};
                     word.last    = (32'(dec_row) == ht - 1) && (col == wd - 1);
                     word.error   = 1'b0;
                     pending_pixels.push_back(word);
                     if (word.last) begin
                        dec_phase = PH_DONE;
                        return;
                     end
                  end
               endcase
            end
            if (k + 1 >= row_len) begin
               dec_row_byte = '0;
               dec_row      = dec_row + 12'd1;
               dec_row_base = dec_row_base - 24'(dec_width);
            end else begin
               dec_row_byte = 15'(k + 1);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string field, input logic [23:0] expected,
                                input logic [23:0] actual);
      if (actual !== expected) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, expected, actual);
      end
   endtask

   task automatic check_pixel_word();
      pixel_word_type word;
      if (pending_pixels.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected word, expected none, actual address %0h color %0h",
                     $time, rsp_pixel_address, rsp_pixel_color);
      end else begin
         word = pending_pixels.pop_front();
         compare_field("pixel_address", word.address, rsp_pixel_address);
         compare_field("pixel_color", 24'(word.color), 24'(rsp_pixel_color));
         compare_field("last_pixel", 24'(word.last), 24'(rsp_last_pixel));
         compare_field("header_error", 24'(word.error), 24'(rsp_header_error));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         stall_cycles = 0;
      end else begin
         if (req_push && !req_full) decode_bmp_byte(req_data_byte, req_file_start);
         if (rsp_pop && !rsp_empty) check_pixel_word();
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request && hold_left == 0) hold_left = HOLD_CYCLES;
         if (hold_left != 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
            if (hold_left == 0) hold_request = 1'b0;
         end else begin
            rsp_pop <= !(pop_idle_on && $urandom_range(99) < 33);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic start);
      while (send_idle_on && $urandom_range(99) < 33) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_data_byte  <= value;
      req_file_start <= start;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_file(input logic [31:0] width_raw, input logic [31:0] height_raw,
                            input logic [31:0] offset, input int unsigned extra,
                            input logic [31:0] stop_at, input logic start_flag,
                            input int fill);
      logic [7:0]  header[HDR_BYTES];
      logic [31:0] skip;
      logic [31:0] body;
      logic [31:0] total;
      logic [7:0]  value;
      for (int i = 0; i < HDR_BYTES; i++) header[i] = 8'($urandom);
      for (int j = 0; j < 4; j++) begin
         header[OFFSET_POS + j] = offset[8*j +: 8];
         header[WIDTH_POS + j]  = width_raw[8*j +: 8];
         header[HEIGHT_POS + j] = height_raw[8*j +: 8];
      end
      skip = (offset > HDR_BYTES && !offset[31]) ? offset - HDR_BYTES : 0;
      if (dim_valid(width_raw, MAX_WIDTH) && dim_valid(height_raw, MAX_HEIGHT))
         body = ((width_raw * 3 + 3) & ~32'd3) * height_raw;
      else
         body = 0;
      total = HDR_BYTES + skip + body + extra;
      if (stop_at < total) total = stop_at;
      for (int unsigned i = 0; i < total; i++) begin
         if (i < HDR_BYTES)
            value = header[i];
         else if (fill < 0)
            value = 8'($urandom);
         else
            value = fill[7:0];
         send_byte(value, (i == 0) ? start_flag : 1'b0);
      end
   endtask

   task automatic send_random_file();
      logic [31:0] width_raw;
      logic [31:0] height_raw;
      logic [31:0] offset;
      logic [31:0] bad;
      logic [31:0] stop_at;
      int unsigned pick;
      width_raw  = $urandom_range(1, 9);
      height_raw = $urandom_range(1, 4);
      if ($urandom_range(99) < 12) begin
         case ($urandom_range(3))
            0: bad = 0;
            1: bad = MAX_WIDTH + 1 + $urandom_range(0, 5000);
            2: bad = $urandom | 32'h8000_0000;
            default: bad = $urandom;
         endcase
         if ($urandom_range(1)) width_raw = bad;
         else height_raw = bad;
      end
      pick = $urandom_range(99);
      if (pick < 50)      offset = HDR_BYTES;
      else if (pick < 70) offset = $urandom_range(0, HDR_BYTES - 1);
      else if (pick < 88) offset = $urandom_range(HDR_BYTES + 1, 90);
      else                offset = $urandom | 32'h8000_0000;
      stop_at = ($urandom_range(99) < 10) ? $urandom_range(1, 120) : NO_TRUNCATION;
      send_file(width_raw, height_raw, offset, $urandom_range(0, 3), stop_at,
                $urandom_range(99) >= 3, RANDOM_FILL);
   endtask

   task automatic test_file_without_start();
      send_file(1, 1, HDR_BYTES, 0, NO_TRUNCATION, 1'b0, RANDOM_FILL);
   endtask

   task automatic test_offsets_and_colors();
      send_file(1, 1, HDR_BYTES, 2, NO_TRUNCATION, 1'b1, 8'hff);
      send_file(2, 1, 0, 0, NO_TRUNCATION, 1'b1, 8'h00);
      send_file(1, 1, HDR_BYTES + 3, 0, NO_TRUNCATION, 1'b1, RANDOM_FILL);
      send_file(1, 2, 32'hffff_fff0, 0, NO_TRUNCATION, 1'b1, RANDOM_FILL);
   endtask

   task automatic test_header_errors();
      send_file(0, 1, HDR_BYTES, 0, NO_TRUNCATION, 1'b1, RANDOM_FILL);
      send_file(1, MAX_HEIGHT + 1, HDR_BYTES, 0, NO_TRUNCATION, 1'b1, RANDOM_FILL);
      send_file(32'h8000_0000, 1, HDR_BYTES, 0, NO_TRUNCATION, 1'b1, RANDOM_FILL);
      send_file(2, 2, HDR_BYTES, 0, 20, 1'b1, RANDOM_FILL);
   endtask

   task automatic test_largest_frames();
      send_file(MAX_WIDTH, MAX_HEIGHT, HDR_BYTES, 0, HDR_BYTES + 9, 1'b1, RANDOM_FILL);
   endtask

   task automatic test_back_to_back();
      send_idle_on = 1'b0;
      pop_idle_on  = 1'b0;
      repeat (2) send_random_file();
      send_idle_on = 1'b1;
      pop_idle_on  = 1'b1;
   endtask

   task automatic test_receiver_hold();
      hold_request = 1'b1;
      send_file(4, 2, HDR_BYTES, 0, NO_TRUNCATION, 1'b1, RANDOM_FILL);
   endtask

   task automatic test_random_files();
      int first_count;
      first_count = bytes_sent;
      while (bytes_sent - first_count < RANDOM_BYTES) send_random_file();
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_file_without_start();
      test_offsets_and_colors();
      test_header_errors();
      test_largest_frames();
      test_back_to_back();
      test_receiver_hold();
      test_random_files();
      req_push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
